### src/tbgd_pkg.sv
// ----------------------------------------------------------------------------
// tbgd_pkg
// Shared types and constants for the two-button gesture detector.
// ----------------------------------------------------------------------------
package tbgd_pkg;

  localparam int DEBOUNCE_W  = 16;
  localparam int HOLD_W      = 20;
  localparam int CFG_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int NOW_W       = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 16'd30;
  localparam logic [HOLD_W-1:0]     LONG_RST      = 20'd1500;
  localparam logic [HOLD_W-1:0]     BOTH_HOLD_RST = 20'd5000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTH_HOLD = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_FIRST_SHORT  = 3'd1,
    EV_FIRST_LONG   = 3'd2,
    EV_SECOND_SHORT = 3'd3,
    EV_SECOND_LONG  = 3'd4,
    EV_BOTH_LONG    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PR_NONE  = 2'd0,
    PR_SHORT = 2'd1,
    PR_LONG  = 2'd2
  } press_t;

  typedef struct packed {
    press_t evt;
    logic   down;
  } lane_stat_t;

endpackage

### src/tbgd_if.sv
// ----------------------------------------------------------------------------
// tbgd_in_if / tbgd_out_if
// Valid/ready channels for polls and gesture events.
// ----------------------------------------------------------------------------
interface tbgd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tbgd_pkg::NOW_W-1:0]  now_ms;
  logic                        first_pressed;
  logic                        second_pressed;

  modport source (output valid, output now_ms, output first_pressed,
                  output second_pressed, input ready);
  modport sink   (input valid, input now_ms, input first_pressed,
                  input second_pressed, output ready);
endinterface

interface tbgd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink   (input valid, input event_res, output ready);
endinterface

### src/tbgd_lane.sv
// ----------------------------------------------------------------------------
// tbgd_lane
// Per-button debounce and short/long press tracking.
// ----------------------------------------------------------------------------
module tbgd_lane #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic                             lvl,
  input  logic [TIME_WIDTH-1:0]            now,
  input  logic [tbgd_pkg::DEBOUNCE_W-1:0]  debounce_time,
  input  logic [tbgd_pkg::HOLD_W-1:0]      long_press_time,
  input  logic                             set_long,
  output tbgd_pkg::lane_stat_t             stat,
  output logic [TIME_WIDTH-1:0]            press_time_nxt,
  output logic [TIME_WIDTH-1:0]            press_elapsed
);

  localparam int CMP_W = (TIME_WIDTH > tbgd_pkg::HOLD_W) ? TIME_WIDTH : tbgd_pkg::HOLD_W;

  logic                  raw_r, raw_nxt;
  logic                  down_r, down_nxt;
  logic                  long_r, long_nxt;
  logic [TIME_WIDTH-1:0] change_r, change_nxt;
  logic [TIME_WIDTH-1:0] press_r;
  logic [TIME_WIDTH-1:0] el_change, el_press;
  logic                  stable, long_due;

  always_comb begin
    el_change = now - change_r;
    el_press  = now - press_r;
    stable    = CMP_W'(el_change) >= CMP_W'(debounce_time);
    long_due  = CMP_W'(el_press) >= CMP_W'(long_press_time);

    raw_nxt        = raw_r;
    change_nxt     = change_r;
    down_nxt       = down_r;
    long_nxt       = long_r;
    press_time_nxt = press_r;
    press_elapsed  = el_press;
    stat.evt       = tbgd_pkg::PR_NONE;

    if (lvl != raw_r) begin
      raw_nxt    = lvl;
      change_nxt = now;
    end else if (stable) begin
      if (lvl && !down_r) begin
        down_nxt       = 1'b1;
        press_time_nxt = now;
        press_elapsed  = '0;
        long_nxt       = 1'b0;
      end else if (lvl && !long_r && long_due) begin
        long_nxt = 1'b1;
        stat.evt = tbgd_pkg::PR_LONG;
      end else if (!lvl && down_r) begin
        down_nxt = 1'b0;
        stat.evt = long_r ? tbgd_pkg::PR_NONE : tbgd_pkg::PR_SHORT;
      end
    end
    stat.down = down_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      down_r   <= 1'b0;
      long_r   <= 1'b0;
      change_r <= '0;
      press_r  <= '0;
    end else if (fire) begin
      raw_r    <= raw_nxt;
      down_r   <= down_nxt;
      long_r   <= long_nxt | set_long;
      change_r <= change_nxt;
      press_r  <= press_time_nxt;
    end
  end

endmodule

### src/tbgd_merge.sv
// ----------------------------------------------------------------------------
// tbgd_merge
// Combines lane findings into one event; tracks the both-held gesture.
// ----------------------------------------------------------------------------
module tbgd_merge #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [tbgd_pkg::HOLD_W-1:0]  both_hold_time,
  input  tbgd_pkg::lane_stat_t         stat0,
  input  tbgd_pkg::lane_stat_t         stat1,
  input  logic [TIME_WIDTH-1:0]        pt0,
  input  logic [TIME_WIDTH-1:0]        pt1,
  input  logic [TIME_WIDTH-1:0]        pel0,
  input  logic [TIME_WIDTH-1:0]        pel1,
  output tbgd_pkg::event_t             ev,
  output logic                         set_long
);

  localparam int CMP_W = (TIME_WIDTH > tbgd_pkg::HOLD_W) ? TIME_WIDTH : tbgd_pkg::HOLD_W;

  logic                  both_done_r, both_done_nxt;
  logic                  both;
  logic [TIME_WIDTH-1:0] el_later;

  always_comb begin
    both          = stat0.down && stat1.down;
    el_later      = (pt0 > pt1) ? pel0 : pel1;
    both_done_nxt = both_done_r;
    set_long      = 1'b0;
    ev            = tbgd_pkg::EV_NONE;
    if (both && !both_done_r && (CMP_W'(el_later) >= CMP_W'(both_hold_time))) begin
      both_done_nxt = 1'b1;
      set_long      = 1'b1;
      ev            = tbgd_pkg::EV_BOTH_LONG;
    end else begin
      if (!stat0.down && !stat1.down) begin
        both_done_nxt = 1'b0;
      end
      if (!both) begin
        if (stat0.evt == tbgd_pkg::PR_SHORT) begin
          ev = tbgd_pkg::EV_FIRST_SHORT;
        end else if (stat0.evt == tbgd_pkg::PR_LONG) begin
          ev = tbgd_pkg::EV_FIRST_LONG;
        end else if (stat1.evt == tbgd_pkg::PR_SHORT) begin
          ev = tbgd_pkg::EV_SECOND_SHORT;
        end else if (stat1.evt == tbgd_pkg::PR_LONG) begin
          ev = tbgd_pkg::EV_SECOND_LONG;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      both_done_r <= 1'b0;
    end else if (fire) begin
      both_done_r <= both_done_nxt;
    end
  end

endmodule

### src/two_button_gesture_detector.sv
// ----------------------------------------------------------------------------
// two_button_gesture_detector
// Debounced short/long/both-long press detection for two buttons.
//
// in_ch carries one poll per request: a millisecond timestamp and the raw
// levels of both buttons. out_ch returns exactly one event code per poll, in
// order (0 none, 1/2 first short/long, 3/4 second short/long, 5 both long).
// cfg_we/cfg_idx/cfg_wdata write the thresholds: index 0 debounce (16 bits),
// 1 long press (20 bits), 2 both-held (20 bits); other indexes are ignored.
// Each event is registered into the output register. Throughput is one poll
// per clock while the receiver keeps up; the per-button lanes and the merge
// stage that close the state loop update on every accepted poll. Reset clears
// all button state, loads thresholds 30/1500/5000 ms and empties the output.
// When the receiver stalls, one more poll is taken into a skid register;
// in_ch.ready then drops until out_ch takes the pending event.
// ----------------------------------------------------------------------------
module two_button_gesture_detector #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tbgd_in_if.sink                         in_ch,
  tbgd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [tbgd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tbgd_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [tbgd_pkg::DEBOUNCE_W-1:0] debounce_r;
  logic [tbgd_pkg::HOLD_W-1:0]     long_r;
  logic [tbgd_pkg::HOLD_W-1:0]     both_hold_r;

  logic                  in_fire, out_fire, in_ready;
  logic                  out_valid_r, skid_valid_r;
  tbgd_pkg::event_t      out_ev_r, skid_ev_r, ev;
  logic [TIME_WIDTH-1:0] now;
  logic                  set_long;
  tbgd_pkg::lane_stat_t  stat0, stat1;
  logic [TIME_WIDTH-1:0] pt0, pt1, pel0, pel1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= tbgd_pkg::DEBOUNCE_RST;
      long_r      <= tbgd_pkg::LONG_RST;
      both_hold_r <= tbgd_pkg::BOTH_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tbgd_pkg::CFG_DEBOUNCE:  debounce_r  <= cfg_wdata[tbgd_pkg::DEBOUNCE_W-1:0];
        tbgd_pkg::CFG_LONG:      long_r      <= cfg_wdata[tbgd_pkg::HOLD_W-1:0];
        tbgd_pkg::CFG_BOTH_HOLD: both_hold_r <= cfg_wdata[tbgd_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign now      = TIME_WIDTH'(in_ch.now_ms);
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_ev_r;

  tbgd_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane0 (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .lvl             (in_ch.first_pressed),
    .now             (now),
    .debounce_time   (debounce_r),
    .long_press_time (long_r),
    .set_long        (set_long),
    .stat            (stat0),
    .press_time_nxt  (pt0),
    .press_elapsed   (pel0)
  );

  tbgd_lane #(.TIME_WIDTH(TIME_WIDTH)) u_lane1 (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .lvl             (in_ch.second_pressed),
    .now             (now),
    .debounce_time   (debounce_r),
    .long_press_time (long_r),
    .set_long        (set_long),
    .stat            (stat1),
    .press_time_nxt  (pt1),
    .press_elapsed   (pel1)
  );

  tbgd_merge #(.TIME_WIDTH(TIME_WIDTH)) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (in_fire),
    .both_hold_time (both_hold_r),
    .stat0          (stat0),
    .stat1          (stat1),
    .pt0            (pt0),
    .pt1            (pt1),
    .pel0           (pel0),
    .pel1           (pel1),
    .ev             (ev),
    .set_long       (set_long)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_ev_r <= skid_ev_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_ev_r <= ev;
      end else begin
        skid_ev_r <= ev;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("request accepted under stall was not held in skid");

  a_no_single_when_both: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && stat0.down && stat1.down) |->
      (ev == tbgd_pkg::EV_NONE || ev == tbgd_pkg::EV_BOTH_LONG))
    else $error("single event reported while both buttons are down");

endmodule

### dv/two_button_gesture_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_gesture_detector_tb
// Self-checking bench for the two-button gesture detector. A poll driver and
// an event monitor run with random idle and stall gaps, plus one long hold-off
// on the event side. A bit-accurate gesture tracker predicts the event of
// every accepted poll. Directed polls cover debounce edges, every event code
// but first short, time wrap and the suppression rules. Randomized button gestures then run
// under several threshold settings, the zero and maximum settings among them.
// ----------------------------------------------------------------------------
module two_button_gesture_detector_tb;

  localparam logic [tbgd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [tbgd_pkg::NOW_W-1:0] now_ms;
    logic                       first_pressed;
    logic                       second_pressed;
  } poll_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tbgd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tbgd_pkg::CFG_W-1:0]     cfg_wdata;

  tbgd_in_if  in_ch ();
  tbgd_out_if out_ch ();

  two_button_gesture_detector #(.TIME_WIDTH(tbgd_pkg::NOW_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Gesture tracker state and threshold mirror.
  logic [tbgd_pkg::DEBOUNCE_W-1:0] bounce_ms;
  logic [tbgd_pkg::HOLD_W-1:0]     long_ms;
  logic [tbgd_pkg::HOLD_W-1:0]     pair_ms;
  logic                            lvl_q      [2];
  logic                            down_q     [2];
  logic [tbgd_pkg::NOW_W-1:0]      changed_at [2];
  logic [tbgd_pkg::NOW_W-1:0]      pressed_at [2];
  logic                            long_fired [2];
  logic                            pair_fired;

  poll_t                      poll_queue [$];
  tbgd_pkg::event_t           expected_events [$];
  logic [tbgd_pkg::NOW_W-1:0] clock_ms;
  int                         send_wait;
  int                         send_run;
  int                         rcv_wait;
  int                         rcv_run;
  int                         hold_left;
  bit                         hold_done;
  int                         err_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic tbgd_pkg::press_t lane_update(input int k, input logic lvl,
                                                   input logic [tbgd_pkg::NOW_W-1:0] now);
    logic [tbgd_pkg::NOW_W-1:0] held;
    if (lvl != lvl_q[k]) begin
      lvl_q[k]      = lvl;
      changed_at[k] = now;
      return tbgd_pkg::PR_NONE;
    end
    held = now - changed_at[k];
    if (held < bounce_ms) return tbgd_pkg::PR_NONE;
    if (lvl && !down_q[k]) begin
      down_q[k]     = 1'b1;
      pressed_at[k] = now;
      long_fired[k] = 1'b0;
      return tbgd_pkg::PR_NONE;
    end
    held = now - pressed_at[k];
    if (lvl && !long_fired[k] && held >= long_ms) begin
      long_fired[k] = 1'b1;
      return tbgd_pkg::PR_LONG;
    end
    if (!lvl && down_q[k]) begin
      down_q[k] = 1'b0;
      return long_fired[k] ? tbgd_pkg::PR_NONE : tbgd_pkg::PR_SHORT;
    end
    return tbgd_pkg::PR_NONE;
  endfunction

  function automatic tbgd_pkg::event_t gesture_step(input logic [tbgd_pkg::NOW_W-1:0] now,
                                                    input logic l0, input logic l1);
    tbgd_pkg::press_t           e0;
    tbgd_pkg::press_t           e1;
    logic                       both;
    logic [tbgd_pkg::NOW_W-1:0] latest;
    logic [tbgd_pkg::NOW_W-1:0] age;
    tbgd_pkg::event_t           ev;
    e0     = lane_update(0, l0, now);
    e1     = lane_update(1, l1, now);
    both   = down_q[0] && down_q[1];
    // plain unsigned compare, no wrap handling
    latest = (pressed_at[0] > pressed_at[1]) ? pressed_at[0] : pressed_at[1];
    age    = now - latest;
    ev     = tbgd_pkg::EV_NONE;
    if (both && !pair_fired && age >= pair_ms) begin
      pair_fired    = 1'b1;
      long_fired[0] = 1'b1;
      long_fired[1] = 1'b1;
      ev            = tbgd_pkg::EV_BOTH_LONG;
    end else begin
      if (!down_q[0] && !down_q[1]) pair_fired = 1'b0;
      if (!both) begin
        if (e0 == tbgd_pkg::PR_SHORT)      ev = tbgd_pkg::EV_FIRST_SHORT;
        else if (e0 == tbgd_pkg::PR_LONG)  ev = tbgd_pkg::EV_FIRST_LONG;
        else if (e1 == tbgd_pkg::PR_SHORT) ev = tbgd_pkg::EV_SECOND_SHORT;
        else if (e1 == tbgd_pkg::PR_LONG)  ev = tbgd_pkg::EV_SECOND_LONG;
      end
    end
    return ev;
  endfunction

  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic push_poll(input logic p0, input logic p1);
    poll_queue.push_back(poll_t'{now_ms: clock_ms, first_pressed: p0, second_pressed: p1});
  endtask

  task automatic hold_buttons(input logic p0, input logic p1, input int unsigned span);
    int unsigned passed;
    int unsigned step_max;
    int unsigned step;
    passed   = 0;
    step_max = span / 3 + 1;
    push_poll(p0, p1);
    while (passed <= span) begin
      step     = $urandom_range(0, step_max);
      clock_ms += step;
      passed   += step;
      push_poll(p0, p1);
    end
  endtask

  task automatic write_reg(input logic [tbgd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbgd_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      tbgd_pkg::CFG_DEBOUNCE:  bounce_ms = data[tbgd_pkg::DEBOUNCE_W-1:0];
      tbgd_pkg::CFG_LONG:      long_ms   = data[tbgd_pkg::HOLD_W-1:0];
      tbgd_pkg::CFG_BOTH_HOLD: pair_ms   = data[tbgd_pkg::HOLD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (poll_queue.size() != 0 || in_ch.valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Poll driver
  always @(posedge clk) begin
    poll_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_wait   <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_events.push_back(gesture_step(in_ch.now_ms, in_ch.first_pressed,
                                               in_ch.second_pressed));
      if (in_ch.valid && !in_ch.ready) begin
        // hold the pending request
      end else if (send_wait > 0) begin
        in_ch.valid <= 1'b0;
        send_wait   <= send_wait - 1;
      end else if (poll_queue.size() != 0) begin
        p = poll_queue.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.now_ms         <= p.now_ms;
        in_ch.first_pressed  <= p.first_pressed;
        in_ch.second_pressed <= p.second_pressed;
        send_wait            <= draw_wait(send_run);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Event monitor
  always @(posedge clk) begin
    int               w;
    int               h;
    tbgd_pkg::event_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rcv_wait     <= 0;
      hold_left    <= 0;
    end else begin
      w = rcv_wait;
      h = hold_left;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          err_cnt++;
          $error("event_res: expected none, actual %0d", out_ch.event_res);
        end else begin
          want = expected_events.pop_front();
          if (out_ch.event_res !== want) begin
            err_cnt++;
            $error("event_res: expected %0d, actual %0d", want, out_ch.event_res);
          end
        end
        w = draw_wait(rcv_run);
      end
      // long hold-off while the driver still has a backlog
      if (!hold_done && poll_queue.size() > 100) begin
        hold_done = 1'b1;
        h         = 200;
      end
      if (h > 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= h - 1;
        rcv_wait     <= w;
      end else if (w > 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= 0;
        rcv_wait     <= w - 1;
      end else begin
        out_ch.ready <= 1'b1;
        hold_left    <= 0;
        rcv_wait     <= 0;
      end
    end
  end

  initial begin
    poll_t opening_polls [24] = '{
      '{32'd0,          1'b1, 1'b0},
      '{32'd29,         1'b1, 1'b0},
      '{32'd30,         1'b1, 1'b0},
      '{32'd1600,       1'b1, 1'b0},
      '{32'd1700,       1'b0, 1'b0},
      '{32'd1730,       1'b0, 1'b0},
      '{32'd1800,       1'b0, 1'b1},
      '{32'd1830,       1'b0, 1'b1},
      '{32'd1900,       1'b0, 1'b0},
      '{32'd1930,       1'b0, 1'b0},
      '{32'd2000,       1'b0, 1'b1},
      '{32'd2030,       1'b0, 1'b1},
      '{32'd3530,       1'b0, 1'b1},
      '{32'hFFFF_FF00,  1'b1, 1'b1},
      '{32'hFFFF_FF20,  1'b1, 1'b1},
      '{32'h0000_1300,  1'b1, 1'b1},
      '{32'h0000_1400,  1'b0, 1'b1},
      '{32'h0000_1500,  1'b0, 1'b1},
      '{32'h0000_1600,  1'b1, 1'b1},
      '{32'h0000_1620,  1'b1, 1'b1},
      '{32'h0000_1D00,  1'b1, 1'b1},
      '{32'h0000_1E00,  1'b0, 1'b0},
      '{32'h0000_1E20,  1'b0, 1'b0},
      '{32'hFFFF_FFFF,  1'b0, 1'b0}
    };
    int                              phase;
    logic [tbgd_pkg::DEBOUNCE_W-1:0] deb;
    logic [tbgd_pkg::HOLD_W-1:0]     lg;
    logic [tbgd_pkg::HOLD_W-1:0]     pr;
    logic [1:0]                      lv;
    int unsigned                     span;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = tbgd_pkg::CFG_DEBOUNCE;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.now_ms         = '0;
    in_ch.first_pressed  = 1'b0;
    in_ch.second_pressed = 1'b0;
    out_ch.ready         = 1'b0;
    bounce_ms            = tbgd_pkg::DEBOUNCE_RST;
    long_ms              = tbgd_pkg::LONG_RST;
    pair_ms              = tbgd_pkg::BOTH_HOLD_RST;
    for (int k = 0; k < 2; k++) begin
      lvl_q[k]      = 1'b0;
      down_q[k]     = 1'b0;
      changed_at[k] = '0;
      pressed_at[k] = '0;
      long_fired[k] = 1'b0;
    end
    pair_fired = 1'b0;
    clock_ms   = '0;
    send_run   = 0;
    rcv_run    = 0;
    hold_done  = 1'b0;
    err_cnt    = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_polls[i]) poll_queue.push_back(opening_polls[i]);
    wait_idle();

    for (phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0: begin
          deb = tbgd_pkg::DEBOUNCE_RST;
          lg  = tbgd_pkg::LONG_RST;
          pr  = tbgd_pkg::BOTH_HOLD_RST;
        end
        1: begin
          deb = '0;
          lg  = '0;
          pr  = '0;
        end
        2: begin
          deb = '1;
          lg  = '1;
          pr  = '1;
        end
        3: begin
          deb = tbgd_pkg::DEBOUNCE_W'($urandom_range(0, 6));
          lg  = tbgd_pkg::HOLD_W'($urandom_range(0, 40));
          pr  = tbgd_pkg::HOLD_W'($urandom_range(0, 90));
        end
        default: begin
          deb = tbgd_pkg::DEBOUNCE_W'($urandom);
          lg  = tbgd_pkg::HOLD_W'($urandom);
          pr  = tbgd_pkg::HOLD_W'($urandom);
        end
      endcase
      // upper bits of the debounce write must be dropped
      write_reg(tbgd_pkg::CFG_DEBOUNCE, {4'($urandom), deb});
      write_reg(CFG_UNUSED, tbgd_pkg::CFG_W'($urandom));
      write_reg(tbgd_pkg::CFG_LONG, lg);
      write_reg(tbgd_pkg::CFG_BOTH_HOLD, pr);

      if ($urandom_range(0, 2) == 0) begin
        clock_ms = '1;
        clock_ms -= $urandom_range(0, 3000000);
      end else begin
        clock_ms = $urandom;
      end

      while (poll_queue.size() < 160) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) begin
            clock_ms = $urandom;
            push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
        end else begin
          repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 3)) begin
              clock_ms += $urandom_range(0, bounce_ms / 2);
              push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            lv = ($urandom_range(0, 2) == 0) ? 2'b11 : 2'($urandom_range(1, 3));
            case ($urandom_range(0, 3))
              0: span = $urandom_range(0, bounce_ms);
              1: span = bounce_ms + $urandom_range(0, long_ms);
              2: span = bounce_ms + long_ms + $urandom_range(0, long_ms / 2 + 5);
              default: span = bounce_ms + pair_ms + $urandom_range(0, pair_ms / 2 + 5);
            endcase
            hold_buttons(lv[1], lv[0], span);
          end
          hold_buttons(1'b0, 1'b0, bounce_ms + $urandom_range(1, 20));
        end
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
